>>> design/dqs_pkg.sv
`default_nettype none

package dqs_pkg;

  // Depth of the deque; every derived width follows from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned OCC_W    = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  // What a cell loads on the next edge.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_TAKE_PREV,
    OP_TAKE_NEXT,
    OP_LOAD
  } cell_op_e;

endpackage

`default_nettype wire

>>> design/deque_with_search.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values, CAPACITY entries deep,
// built as a chain of cells that always hold the entries in order from the
// front (cell 0) to the back. Every command transfer gives exactly one result
// transfer. Push front shifts the chain one place toward the back and loads
// cell 0; push back loads the cell just past the last entry; pop front
// shifts the chain toward the front; pop back only shrinks the count. For
// these the result sits in the output register the cycle after the command
// transfer. A search rotates the whole chain once around past a comparator
// on cell 0, one place per cycle, whatever the fill level, and leaves the
// chain as it found it. The block takes a new command whenever it is not
// searching and the output register is empty or being read in the same
// cycle. Overflowing pushes and underflowing pops change nothing; unused
// command codes return status ok with occupancy unchanged.
module deque_with_search import dqs_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic        [CMD_W-1:0]    command_i,
  input  wire logic signed [DATA_W-1:0]   value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [STATUS_W-1:0] status_o,
  output logic signed      [DATA_W-1:0]   popped_value_o,
  output logic             [POS_W-1:0]    found_position_o,
  output logic             [OCC_W-1:0]    occupancy_o
);

  // Sequencer states.
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] step_q, step_d;     // rotation step of a search
  logic             found_q, found_d;
  logic [IDX_W-1:0] pos_q, pos_d;       // first hit position
  logic [DATA_W-1:0] key_q, key_d;      // search key

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   popped_q, popped_d;
  logic [IDX_W-1:0]    fpos_q, fpos_d;
  logic [CNT_W-1:0]    occ_q, occ_d;

  // Cell chain.
  cell_op_e          cell_op [CAPACITY];
  logic [DATA_W-1:0] cell_val [CAPACITY];

  logic in_fire, out_fire, is_full, is_empty, hit, last_step;
  logic [IDX_W-1:0] back_idx;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign is_full    = (count_q == CNT_W'(CAPACITY));
  assign is_empty   = (count_q == '0);
  assign back_idx   = IDX_W'(count_q - CNT_W'(1));

  // Cell 0 is the head; only occupied positions count as hits.
  assign hit       = (cell_val[0] == key_q) && (CNT_W'(step_q) < count_q);
  assign last_step = (step_q == IDX_W'(CAPACITY - 1));

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_head
      assign prev_w = value_i;
    end else begin : g_body
      assign prev_w = cell_val[g-1];
    end
    // Last cell wraps to the head so a search can rotate the chain.
    if (g == CAPACITY - 1) begin : g_tail
      assign next_w = cell_val[0];
    end else begin : g_mid
      assign next_w = cell_val[g+1];
    end
    dqs_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .load_i  (value_i),
      .value_o (cell_val[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    found_d     = found_q;
    pos_d       = pos_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_fire;
    status_d    = status_q;
    popped_d    = popped_q;
    fpos_d      = fpos_q;
    occ_d       = occ_q;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = OP_HOLD;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          popped_d    = '0;
          fpos_d      = '0;
          unique case (command_i)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_d = STAT_OVERFLOW;
              end else begin
                cell_op[0] = OP_LOAD;
                for (int i = 1; i < CAPACITY; i++) begin
                  cell_op[i] = OP_TAKE_PREV;
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status_d = STAT_OVERFLOW;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == count_q) begin
                    cell_op[i] = OP_LOAD;
                  end
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                status_d = STAT_UNDERFLOW;
              end else begin
                popped_d = cell_val[0];
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_op[i] = OP_TAKE_NEXT;
                end
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                status_d = STAT_UNDERFLOW;
              end else begin
                popped_d = cell_val[back_idx];
                count_d  = count_q - CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              // Result comes at the end of the rotation.
              out_valid_d = 1'b0;
              state_d     = S_SEARCH;
              key_d       = value_i;
              step_d      = '0;
              found_d     = 1'b0;
              pos_d       = '0;
            end
            default: begin
              // unused codes: ignored
            end
          endcase
          occ_d = count_d;
        end
      end
      S_SEARCH: begin
        for (int i = 0; i < CAPACITY; i++) begin
          cell_op[i] = OP_TAKE_NEXT;
        end
        step_d = step_q + IDX_W'(1);
        if (hit && !found_q) begin
          found_d = 1'b1;
          pos_d   = step_q;
        end
        if (last_step) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = found_d ? STAT_OK : STAT_NOT_FOUND;
          popped_d    = '0;
          fpos_d      = found_d ? pos_d : '0;
          occ_d       = count_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    status_q <= status_d;
    popped_q <= popped_d;
    fpos_q   <= fpos_d;
    occ_q    <= occ_d;
  end

  // Fit internal widths to the fixed result fields (mask or zero-extend).
  logic [31:0] fpos_ext, occ_ext;
  assign fpos_ext = 32'(fpos_q);
  assign occ_ext  = 32'(occ_q);

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign popped_value_o   = popped_q;
  assign found_position_o = fpos_ext[POS_W-1:0];
  assign occupancy_o      = occ_ext[OCC_W-1:0];

endmodule

`default_nettype wire

>>> design/dqs_cell.sv
`default_nettype none

module dqs_cell import dqs_pkg::*; (
  input  wire logic              clk_i,
  input  wire cell_op_e          op_i,
  input  wire logic [DATA_W-1:0] prev_i,
  input  wire logic [DATA_W-1:0] next_i,
  input  wire logic [DATA_W-1:0] load_i,
  output logic      [DATA_W-1:0] value_o
);

  logic [DATA_W-1:0] value_q, value_d;

  always_comb begin
    case (op_i)
      OP_TAKE_PREV: value_d = prev_i;
      OP_TAKE_NEXT: value_d = next_i;
      OP_LOAD:      value_d = load_i;
      default:      value_d = value_q;
    endcase
  end

  // Payload only, no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

>>> design/dqs_checker.sv
`default_nettype none

module dqs_checker import dqs_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_o,
  input wire logic [DATA_W-1:0]   popped_value_o,
  input wire logic [POS_W-1:0]    found_position_o,
  input wire logic [OCC_W-1:0]    occupancy_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(popped_value_o) && $stable(found_position_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // Underflow only on an empty queue, with nothing popped.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_UNDERFLOW |-> popped_value_o == '0 && occupancy_o == '0)
    else $error("bad underflow result");

  // Overflow only on a full queue.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OVERFLOW |-> occupancy_o == OCC_W'(CAPACITY))
    else $error("overflow below capacity");

  // A missed search reports no position and no value.
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_NOT_FOUND |-> found_position_o == '0
      && popped_value_o == '0)
    else $error("bad not-found result");

  // No new command while a result still waits and is not being taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("command taken while result stalled");

endmodule

bind deque_with_search dqs_checker u_dqs_checker (.*);

`default_nettype wire
